// ===== design/tdq_pkg.sv =====
// ============================================================================
// tdq_pkg: shared types and constants for the task dispatch queue
// Field widths, result and operation codes, and the control structs that
// the top level hands to the queue and sort cells.
// ============================================================================
package tdq_pkg;

    localparam int TASK_W        = 16;
    localparam int CNT_W         = 7;
    localparam int KIND_W        = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CNT_W-1:0] BATCH_LIMIT_RESET = 7'd10;

    // operation codes
    localparam logic OP_PUSH     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TASK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic shift;
        logic push;
    } queue_ctl_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } sort_ctl_t;

endpackage

// ===== design/tdq_req_if.sv =====
// ============================================================================
// tdq_req_if: request channel of the task dispatch queue
// Valid/ready handshake carrying one push or dispatch request.
// ============================================================================
interface tdq_req_if;

    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [tdq_pkg::TASK_W-1:0]  task_value;
    logic [tdq_pkg::CNT_W-1:0]   ready_workers;

    modport source (output valid, output operation, output task_value,
                    output ready_workers, input ready);
    modport sink   (input valid, input operation, input task_value,
                    input ready_workers, output ready);

endinterface

// ===== design/tdq_rsp_if.sv =====
// ============================================================================
// tdq_rsp_if: response channel of the task dispatch queue
// Valid/ready handshake carrying one acknowledge or dispatched task.
// ============================================================================
interface tdq_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [tdq_pkg::KIND_W-1:0]  kind;
    logic [tdq_pkg::TASK_W-1:0]  out_task;
    logic                        last;
    logic [tdq_pkg::CNT_W-1:0]   offered_slots;
    logic [tdq_pkg::CNT_W-1:0]   drop_count;
    logic                        overflow;

    modport source (output valid, output kind, output out_task, output last,
                    output offered_slots, output drop_count, output overflow,
                    input ready);
    modport sink   (input valid, input kind, input out_task, input last,
                    input offered_slots, input drop_count, input overflow,
                    output ready);

endinterface

// ===== design/tdq_queue_cell.sv =====
// ============================================================================
// tdq_queue_cell: one slot of the arrival-order task chain
// Take the right neighbor's task on shift, or the pushed task on push.
// ============================================================================
module tdq_queue_cell (
    input  logic                        clk,
    input  tdq_pkg::queue_ctl_t         ctl,
    input  logic [tdq_pkg::TASK_W-1:0]  task_in,
    input  logic [tdq_pkg::TASK_W-1:0]  right_val,
    output logic [tdq_pkg::TASK_W-1:0]  val
);

    logic [tdq_pkg::TASK_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            val_reg <= right_val;
        end
        else if (ctl.push)
        begin
            val_reg <= task_in;
        end
    end

    assign val = val_reg;

endmodule

// ===== design/tdq_sort_cell.sv =====
// ============================================================================
// tdq_sort_cell: one slot of the descending insertion sort chain
// On insert, keep, take the new task, or take the left neighbor's task;
// on pop, take the right neighbor's task.
// ============================================================================
module tdq_sort_cell (
    input  logic                        clk,
    input  tdq_pkg::sort_ctl_t          ctl,
    input  logic                        occupied,
    input  logic [tdq_pkg::TASK_W-1:0]  new_val,
    input  logic [tdq_pkg::TASK_W-1:0]  left_val,
    input  logic                        left_ge,
    input  logic [tdq_pkg::TASK_W-1:0]  right_val,
    output logic [tdq_pkg::TASK_W-1:0]  val,
    output logic                        ge
);

    logic [tdq_pkg::TASK_W-1:0] val_reg;

    // ge: this cell holds a task that stays ahead of the new one
    assign ge = occupied && (val_reg >= new_val);

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            if (!ge)
            begin
                val_reg <= left_ge ? new_val : left_val;
            end
        end
        else if (ctl.pop)
        begin
            val_reg <= right_val;
        end
    end

    assign val = val_reg;

endmodule

// ===== design/task_dispatch_queue.sv =====
// ============================================================================
// task_dispatch_queue: task buffer with sorted batch dispatch
// Usage:
//   req carries push or dispatch transactions (valid/ready); rsp returns
//   results (valid/ready). batch_limit is written through cfg_wr_en and
//   cfg_wr_data, by the user only while the block is idle; no check enforces it.
//   A push appends the task to the arrival-order chain, or drops it if the
//   chain is full, and answers with one acknowledge (offered slots, drop
//   count, overflow when full). A dispatch takes min(fill, ready_workers)
//   oldest tasks and returns them in descending order, last set on the final
//   one; with nothing to take it returns one empty marker.
// Request flow:
//   A request is latched in a one-deep holding register; req.ready drops only
//   while that register is full, so a request is taken while a result waits.
//   A push is then handled by the controller in S_IDLE, which writes its
//   acknowledge into the output register once that register is free. A
//   dispatch of n tasks moves them one per cycle from the head of the queue
//   chain into the sort chain, then pops them one per cycle from the sort
//   chain, pausing while the output register is held by rsp.ready low.
// Reset:
//   rst_n clears fill count, controller state and holding flags and sets
//   batch_limit to 10. Task storage is not cleared.
// Stall:
//   When rsp.ready is low the result holds in the output register and the
//   controller waits before its next result; no result is lost or repeated.
// ============================================================================
module task_dispatch_queue #(
    parameter int DEPTH = tdq_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tdq_pkg::CNT_W-1:0]   cfg_wr_data,
    tdq_req_if.sink                     req,
    tdq_rsp_if.source                   rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t                         state_reg, state_next;

    // request holding register
    logic                           pend_vld_reg, pend_vld_next;
    logic                           pend_op_reg, pend_op_next;
    logic [tdq_pkg::TASK_W-1:0]     pend_task_reg, pend_task_next;
    logic [tdq_pkg::CNT_W-1:0]      pend_ready_reg, pend_ready_next;

    // occupancy and batch counters
    logic [CW-1:0]                  fill_reg, fill_next;
    logic [CW-1:0]                  load_cnt_reg, load_cnt_next;
    logic [CW-1:0]                  sort_cnt_reg, sort_cnt_next;
    logic [tdq_pkg::CNT_W-1:0]      bl_reg, bl_next;

    // output register
    logic                           out_vld_reg, out_vld_next;
    logic [tdq_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [tdq_pkg::TASK_W-1:0]     out_task_reg, out_task_next;
    logic                           out_last_reg, out_last_next;
    logic [tdq_pkg::CNT_W-1:0]      out_offered_reg, out_offered_next;
    logic [tdq_pkg::CNT_W-1:0]      out_drop_reg, out_drop_next;
    logic                           out_ovf_reg, out_ovf_next;

    // cell chains
    logic [tdq_pkg::TASK_W-1:0]     q_val    [DEPTH];
    logic [tdq_pkg::TASK_W-1:0]     sort_val [DEPTH];
    logic                           sort_ge  [DEPTH];
    logic                           q_shift;
    logic                           q_push;
    tdq_pkg::sort_ctl_t             s_ctl;

    // push arithmetic
    logic                           in_acc;
    logic                           out_free;
    logic                           full;
    logic [CW-1:0]                  fill_after;
    logic [tdq_pkg::CNT_W-1:0]      free_slots;
    logic                           short_fall;
    logic [CW-1:0]                  n_take;

    assign in_acc   = req.valid && !pend_vld_reg;
    assign out_free = !out_vld_reg || rsp.ready;

    assign full       = (fill_reg == CW'(DEPTH));
    assign fill_after = full ? fill_reg : fill_reg + CW'(1);
    assign free_slots = tdq_pkg::CNT_W'(DEPTH) - tdq_pkg::CNT_W'(fill_after);
    assign short_fall = (free_slots < bl_reg);

    // batch size: the held tasks, capped by the ready workers
    assign n_take = (tdq_pkg::CNT_W'(fill_reg) < pend_ready_reg)
                    ? fill_reg : CW'(pend_ready_reg);

    // ------------------------------------------------------------------
    // Queue chain: cell 0 holds the oldest task. Shift toward cell 0
    // while loading the sorter; write a push into the first free cell.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_queue
            tdq_pkg::queue_ctl_t         qc;
            logic [tdq_pkg::TASK_W-1:0]  right;

            assign qc.shift = q_shift;
            assign qc.push  = q_push && (fill_reg == CW'(gi));

            if (gi == DEPTH - 1)
            begin : g_end
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = q_val[gi + 1];
            end

            tdq_queue_cell u_cell (
                .clk       (clk),
                .ctl       (qc),
                .task_in   (pend_task_reg),
                .right_val (right),
                .val       (q_val[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Sort chain: cell 0 holds the largest task. Insert one task a cycle
    // from the queue head; pop one a cycle toward the output while it is free.
    // ------------------------------------------------------------------
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_sort
            logic [tdq_pkg::TASK_W-1:0]  left;
            logic                        lge;
            logic [tdq_pkg::TASK_W-1:0]  right;

            if (gi == 0)
            begin : g_first
                // nothing sits ahead of the head cell: it takes the new task unless it keeps its own
                assign left = '0;
                assign lge  = 1'b1;
            end
            else
            begin : g_next
                assign left = sort_val[gi - 1];
                assign lge  = sort_ge[gi - 1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = sort_val[gi + 1];
            end

            tdq_sort_cell u_cell (
                .clk       (clk),
                .ctl       (s_ctl),
                .occupied  (CW'(gi) < sort_cnt_reg),
                .new_val   (q_val[0]),
                .left_val  (left),
                .left_ge   (lge),
                .right_val (right),
                .val       (sort_val[gi]),
                .ge        (sort_ge[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        pend_vld_next    = pend_vld_reg;
        pend_op_next     = pend_op_reg;
        pend_task_next   = pend_task_reg;
        pend_ready_next  = pend_ready_reg;
        fill_next        = fill_reg;
        load_cnt_next    = load_cnt_reg;
        sort_cnt_next    = sort_cnt_reg;
        bl_next          = cfg_wr_en ? cfg_wr_data : bl_reg;
        out_vld_next     = out_vld_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_task_next    = out_task_reg;
        out_last_next    = out_last_reg;
        out_offered_next = out_offered_reg;
        out_drop_next    = out_drop_reg;
        out_ovf_next     = out_ovf_reg;
        q_shift          = 1'b0;
        q_push           = 1'b0;
        s_ctl.ins        = 1'b0;
        s_ctl.pop        = 1'b0;

        // latch a new transaction into the holding register
        if (in_acc)
        begin
            pend_vld_next   = 1'b1;
            pend_op_next    = req.operation;
            pend_task_next  = req.task_value;
            pend_ready_next = req.ready_workers;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pend_vld_reg && out_free)
                begin
                    pend_vld_next = 1'b0;
                    if (pend_op_reg == tdq_pkg::OP_PUSH)
                    begin
                        // drop the task when full, report counts anyway
                        q_push           = !full;
                        fill_next        = fill_after;
                        out_vld_next     = 1'b1;
                        out_kind_next    = tdq_pkg::KIND_PUSH;
                        out_task_next    = '0;
                        out_last_next    = 1'b1;
                        out_offered_next = short_fall ? free_slots : bl_reg;
                        out_drop_next    = short_fall ? bl_reg - free_slots : '0;
                        out_ovf_next     = full;
                    end
                    else if (n_take == '0)
                    begin
                        out_vld_next     = 1'b1;
                        out_kind_next    = tdq_pkg::KIND_EMPTY;
                        out_task_next    = '0;
                        out_last_next    = 1'b1;
                        out_offered_next = '0;
                        out_drop_next    = '0;
                        out_ovf_next     = 1'b0;
                    end
                    else
                    begin
                        load_cnt_next = n_take;
                        sort_cnt_next = '0;
                        state_next    = S_LOAD;
                    end
                end
            end

            S_LOAD:
            begin
                // advance the oldest task into the sorter
                q_shift       = 1'b1;
                s_ctl.ins     = 1'b1;
                fill_next     = fill_reg - CW'(1);
                load_cnt_next = load_cnt_reg - CW'(1);
                sort_cnt_next = sort_cnt_reg + CW'(1);
                if (load_cnt_reg == CW'(1))
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    s_ctl.pop        = 1'b1;
                    out_vld_next     = 1'b1;
                    out_kind_next    = tdq_pkg::KIND_TASK;
                    out_task_next    = sort_val[0];
                    out_last_next    = (sort_cnt_reg == CW'(1));
                    out_offered_next = '0;
                    out_drop_next    = '0;
                    out_ovf_next     = 1'b0;
                    sort_cnt_next    = sort_cnt_reg - CW'(1);
                    if (sort_cnt_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            fill_reg     <= '0;
            load_cnt_reg <= '0;
            sort_cnt_reg <= '0;
            bl_reg       <= tdq_pkg::BATCH_LIMIT_RESET;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            fill_reg     <= fill_next;
            load_cnt_reg <= load_cnt_next;
            sort_cnt_reg <= sort_cnt_next;
            bl_reg       <= bl_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pend_op_reg     <= pend_op_next;
        pend_task_reg   <= pend_task_next;
        pend_ready_reg  <= pend_ready_next;
        out_kind_reg    <= out_kind_next;
        out_task_reg    <= out_task_next;
        out_last_reg    <= out_last_next;
        out_offered_reg <= out_offered_next;
        out_drop_reg    <= out_drop_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign req.ready         = !pend_vld_reg;
    assign rsp.valid         = out_vld_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.out_task      = out_task_reg;
    assign rsp.last          = out_last_reg;
    assign rsp.offered_slots = out_offered_reg;
    assign rsp.drop_count    = out_drop_reg;
    assign rsp.overflow      = out_ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (sort_cnt_reg != '0))
        else $error("emit with empty sort chain");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && sort_cnt_reg >= CW'(2)) |->
        (sort_val[0] >= sort_val[1]))
        else $error("sort chain head out of order");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_ovf_reg) |-> (fill_reg == CW'(DEPTH)))
        else $error("overflow reported while not full");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && load_cnt_reg == CW'(1)) |=>
        (state_reg == S_EMIT))
        else $error("load phase did not hand over to emit");

endmodule

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for task_dispatch_queue
// Drives push and dispatch transactions on the request channel and checks
// every response against a cycle-free model of the queue. The model keeps
// the stored tasks, head, fill and batch_limit, and sorts each dispatched
// batch. The bench walks batch_limit through its extremes between phases.
// It idles both channels at random and holds the response side off once
// long enough to fill the block and stall its input.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = tdq_pkg::DEPTH_DEFAULT;

    // one response transaction as the bench expects or sees it
    typedef struct packed {
        logic [tdq_pkg::KIND_W-1:0] kind;
        logic [tdq_pkg::TASK_W-1:0] value;
        logic                       last;
        logic [tdq_pkg::CNT_W-1:0]  offered;
        logic [tdq_pkg::CNT_W-1:0]  dropped;
        logic                       ovf;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [tdq_pkg::CNT_W-1:0] cfg_wr_data;

    tdq_req_if req_ch ();
    tdq_rsp_if rsp_ch ();

    task_dispatch_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // queue model: stored tasks, oldest at model_head
    logic [tdq_pkg::TASK_W-1:0] model_store [QDEPTH];
    int                         model_head;
    int                         model_fill;
    int                         model_limit;

    // responses still owed by the block, oldest first
    result_t pending_results[$];

    int  err_count;
    bit  send_idle_en;
    bit  recv_idle_en;
    int  hold_request;

    // coverage tallies for the closing summary
    int  n_push;
    int  n_overflow;
    int  n_dispatch;
    int  n_sent_tasks;
    int  n_empty;
    int  n_limits;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Model: advance the queue by one accepted request and queue the
    // responses it must produce.
    // ------------------------------------------------------------------------
    task automatic model_accept(input logic op,
                                input logic [tdq_pkg::TASK_W-1:0] val,
                                input logic [tdq_pkg::CNT_W-1:0] workers);
        result_t                    r;
        logic [tdq_pkg::TASK_W-1:0] batch [QDEPTH];
        logic [tdq_pkg::TASK_W-1:0] v;
        int                         n;
        int                         free_slots;
        int                         i;
        int                         j;

        r      = '0;
        r.last = 1'b1;
        if (op == tdq_pkg::OP_PUSH)
        begin
            n_push++;
            r.kind = tdq_pkg::KIND_PUSH;
            // a full buffer discards the task but still reports counts
            if (model_fill >= QDEPTH)
            begin
                r.ovf = 1'b1;
                n_overflow++;
            end
            else
            begin
                model_store[(model_head + model_fill) % QDEPTH] = val;
                model_fill++;
            end
            free_slots = QDEPTH - model_fill;
            if (free_slots < model_limit)
            begin
                r.offered = free_slots[tdq_pkg::CNT_W-1:0];
                r.dropped = tdq_pkg::CNT_W'(model_limit - free_slots);
            end
            else
            begin
                r.offered = model_limit[tdq_pkg::CNT_W-1:0];
            end
            pending_results.push_back(r);
        end
        else
        begin
            n_dispatch++;
            n = (model_fill < int'(workers)) ? model_fill : int'(workers);
            if (n == 0)
            begin
                // nothing to send: one marker, buffer untouched
                r.kind = tdq_pkg::KIND_EMPTY;
                n_empty++;
                pending_results.push_back(r);
            end
            else
            begin
                for (i = 0; i < n; i++)
                    batch[i] = model_store[(model_head + i) % QDEPTH];
                model_head = (model_head + n) % QDEPTH;
                model_fill = model_fill - n;
                // sort the batch, largest value first
                for (i = 1; i < n; i++)
                begin
                    v = batch[i];
                    j = i;
                    while (j > 0 && batch[j-1] < v)
                    begin
                        batch[j] = batch[j-1];
                        j--;
                    end
                    batch[j] = v;
                end
                for (i = 0; i < n; i++)
                begin
                    r       = '0;
                    r.kind  = tdq_pkg::KIND_TASK;
                    r.value = batch[i];
                    r.last  = (i == n - 1);
                    pending_results.push_back(r);
                end
                n_sent_tasks += n;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one request, optionally after a short idle burst, and
    // hold it until the block takes it. Ready is sampled at the falling
    // edge, so the transaction completes at the following rising edge.
    // Call and return at a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [tdq_pkg::TASK_W-1:0] val,
                             input logic [tdq_pkg::CNT_W-1:0] workers);
        int gap;

        if (send_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.task_value    <= val;
        req_ch.ready_workers <= workers;
        do
            @(negedge clk);
        while (req_ch.ready !== 1'b1);
        model_accept(op, val, workers);
        @(posedge clk);
    endtask

    task automatic push_task(input logic [tdq_pkg::TASK_W-1:0] val);
        send_item(tdq_pkg::OP_PUSH, val, tdq_pkg::CNT_W'($urandom_range(0, 127)));
    endtask

    task automatic dispatch_to(input logic [tdq_pkg::CNT_W-1:0] workers);
        send_item(tdq_pkg::OP_DISPATCH, tdq_pkg::TASK_W'($urandom), workers);
    endtask

    // Drop valid, wait for every owed response, then let the pipeline settle.
    task automatic wait_idle(input int tail);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Write batch_limit; only called with the block idle.
    task automatic write_batch_limit(input logic [tdq_pkg::CNT_W-1:0] limit);
        wait_idle(4);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_limit = int'(limit);
        n_limits++;
    endtask

    // Random traffic: mostly pushes so the buffer fills and overflows, with
    // dispatches of few workers, no workers, and more workers than tasks.
    task automatic random_traffic(input int count);
        int k;
        int pick;

        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_task(tdq_pkg::TASK_W'($urandom));
            else if (pick < 64)
                dispatch_to('0);
            else if (pick < 92)
                dispatch_to(tdq_pkg::CNT_W'($urandom_range(1, 8)));
            else
                dispatch_to(tdq_pkg::CNT_W'($urandom_range(9, 127)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: ready with random idle bursts, plus a long hold when a
    // test asks for one. One assignment to ready per edge.
    // ------------------------------------------------------------------------
    initial
    begin
        int   burst;
        int   hold;
        logic rdy;

        burst = 0;
        hold  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                rdy = 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                rdy = 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 4);
                rdy   = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            rsp_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each response transaction with the oldest expectation.
    // Sampled at the falling edge, ahead of the edge that completes it.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        result_t got;
        result_t want;

        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.kind    = rsp_ch.kind;
            got.value   = rsp_ch.out_task;
            got.last    = rsp_ch.last;
            got.offered = rsp_ch.offered_slots;
            got.dropped = rsp_ch.drop_count;
            got.ovf     = rsp_ch.overflow;
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result kind=%0d task=%h last=%b",
                         $realtime, got.kind, got.value, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    $display({"%0t: mismatch expected kind=%0d task=%h last=%b ",
                              "offered=%0d drop=%0d ovf=%b, actual kind=%0d ",
                              "task=%h last=%b offered=%0d drop=%0d ovf=%b"},
                             $realtime, want.kind, want.value, want.last,
                             want.offered, want.dropped, want.ovf,
                             got.kind, got.value, got.last,
                             got.offered, got.dropped, got.ovf);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty markers: dispatch on an empty buffer and with zero workers,
    // then drain a short buffer one task and then many workers at a time.
    task automatic test_empty_dispatch();
        dispatch_to('0);
        dispatch_to(7'd64);
        push_task(16'h0001);
        push_task(16'hFFFF);
        dispatch_to('0);
        dispatch_to(7'd1);
        dispatch_to(7'd127);
    endtask

    // Fill to capacity with the extreme values, overflow twice, then hand
    // everything to more workers than tasks held.
    task automatic test_fill_overflow();
        int k;

        push_task(16'h0000);
        push_task(16'hFFFF);
        push_task(16'hAAAA);
        push_task(16'h5555);
        push_task(16'h8000);
        push_task(16'h1234);
        push_task(16'h1234);
        for (k = 7; k < QDEPTH; k++)
            push_task(tdq_pkg::TASK_W'($urandom));
        push_task(16'hFFFF);
        push_task(16'h0000);
        dispatch_to(7'd20);
    endtask

    // Sweep batch_limit: zero, one, the depth, the middle of the range, the
    // largest register value, then a random setting; traffic in each.
    task automatic test_limit_sweep();
        int limits [6];
        int k;

        limits = '{0, 1, QDEPTH, 64, 127, 0};
        limits[5] = $urandom_range(0, 127);
        for (k = 0; k < 6; k++)
        begin
            write_batch_limit(tdq_pkg::CNT_W'(limits[k]));
            random_traffic(26);
        end
    endtask

    // Long response hold while the sender keeps offering: the output and
    // holding registers fill and the request side must stall.
    task automatic test_response_hold();
        int k;

        write_batch_limit(tdq_pkg::CNT_W'($urandom_range(1, 40)));
        @(negedge clk);
        hold_request = 150;
        @(posedge clk);
        for (k = 0; k < 14; k++)
            push_task(tdq_pkg::TASK_W'($urandom));
        dispatch_to(7'd16);
        for (k = 0; k < 6; k++)
            push_task(tdq_pkg::TASK_W'($urandom));
        dispatch_to(7'd3);
        random_traffic(8);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        write_batch_limit(tdq_pkg::BATCH_LIMIT_RESET);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        random_traffic(60);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = tdq_pkg::OP_PUSH;
        req_ch.task_value    = '0;
        req_ch.ready_workers = '0;
        model_head   = 0;
        model_fill   = 0;
        model_limit  = int'(tdq_pkg::BATCH_LIMIT_RESET);
        err_count    = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_request = 0;
        n_push       = 0;
        n_overflow   = 0;
        n_dispatch   = 0;
        n_sent_tasks = 0;
        n_empty      = 0;
        n_limits     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_dispatch();
        test_fill_overflow();
        test_limit_sweep();
        test_response_hold();
        test_steady_stream();
        wait_idle(40);

        $display("Covered %0d pushes (%0d overflowed) and %0d dispatches",
                 n_push, n_overflow, n_dispatch);
        $display("  %0d tasks sent, %0d empty markers, %0d batch_limit writes",
                 n_sent_tasks, n_empty, n_limits);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
